[rtl/bms_pkg.sv]
`default_nettype none
package bms_pkg;

	localparam int MAX_ITEMS_DEF = 64;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CHECK,
		ST_MERGE,
		ST_EMIT
	} bms_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic merge;
		logic emit;
	} bms_cmd_t;

	typedef struct packed {
		logic pass_done;
		logic sort_done;
		logic emit_done;
	} bms_sts_t;

endpackage
`default_nettype wire

[rtl/bottom_up_merge_sorter.sv]
// Loading takes one value per cycle; the set is closed by the value with the last mark.
// Sorting runs P = ceil(log2(n)) merge passes from one store to the other, one output per
// cycle, each store having two read ports; emitting follows the last pass.
// Results leave one per cycle when not stalled; the next set is taken once the last is registered.
// Asynchronous active-low reset clears count, internal overflow flag, state, merge pointers and output valid;
// the value stores and output data registers are not cleared.
`default_nettype none
module bottom_up_merge_sorter import bms_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] in_value,
	input  wire logic               in_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      out_value,
	output logic                    out_last,
	output logic                    overflow
);

	bms_cmd_t   cmd;
	bms_sts_t   sts;
	bms_state_t state;

	bms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall),
		.state    (state)
	);

	bms_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (in_value),
		.in_last   (in_last),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_value (out_value),
		.out_last  (out_last),
		.overflow  (overflow)
	);

	a_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (state == ST_LOAD))
		else $error("input transaction outside load state");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state == ST_EMIT))
		else $error("output valid raised outside emit state");

	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_last) |=> !out_valid)
		else $error("output transaction follows last of set");

endmodule
`default_nettype wire

[rtl/bms_ctrl.sv]
`default_nettype none
module bms_ctrl import bms_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_last,
	input  wire bms_sts_t   sts,
	output bms_cmd_t        cmd,
	output logic            in_stall,
	output bms_state_t      state
);

	bms_state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD: begin
				if (in_valid && in_last) st_d = ST_CHECK;
			end
			ST_CHECK: begin
				st_d = sts.sort_done ? ST_EMIT : ST_MERGE;
			end
			ST_MERGE: begin
				if (sts.pass_done) st_d = ST_CHECK;
			end
			ST_EMIT: begin
				if (sts.emit_done) st_d = ST_LOAD;
			end
			default: begin
				st_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (st_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CHECK: begin
				cmd.setup = 1'b1;
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign state = st_q;

endmodule
`default_nettype wire

[rtl/bms_dp.sv]
`default_nettype none
module bms_dp import bms_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bms_cmd_t           cmd,
	output bms_sts_t                sts,
	input  wire logic signed [31:0] in_value,
	input  wire logic               in_last,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output logic signed [31:0]      out_value,
	output logic                    out_last,
	output logic                    overflow
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

	logic [31:0] mem0_q [MAX_ITEMS];
	logic [31:0] mem1_q [MAX_ITEMS];
	logic [31:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	logic [CW-1:0] cnt_q, a_q, b_q, k_q, mid_q, hi_q;
	logic [CW-1:0] a_d, b_d, k_d, mid_d, hi_d;
	logic [CW:0]   w_q;
	logic          src_q, drop_q, out_valid_q;
	logic [31:0]   out_value_q;
	logic          out_last_q, overflow_q;

	logic [31:0]   ra, rb, wdata;
	logic          take_a, run_done, pass_done, emit_adv, emit_last, load_wr;
	logic [CW-1:0] base, run_mid, run_hi, k_inc, a_inc;

	function automatic logic [CW-1:0] clip(input logic [CW+1:0] s, input logic [CW-1:0] n);
		return (s > {2'b00, n}) ? n : s[CW-1:0];
	endfunction

	always_comb begin
		ra        = src_q ? rd1a_q : rd0a_q;
		rb        = src_q ? rd1b_q : rd0b_q;
		take_a    = (a_q < mid_q) && (!(b_q < hi_q) || ($signed(ra) < $signed(rb)));
		wdata     = take_a ? ra : rb;
		k_inc     = k_q + 1'b1;
		a_inc     = a_q + 1'b1;
		run_done  = (k_inc == hi_q);
		pass_done = cmd.merge && run_done && (hi_q == cnt_q);
		emit_adv  = cmd.emit && (!out_valid_q || !out_stall);
		emit_last = (a_inc == cnt_q);
		load_wr   = cmd.load && (cnt_q < MaxCnt);
		base      = cmd.setup ? '0 : hi_q;
		run_mid   = clip({2'b00, base} + {1'b0, w_q}, cnt_q);
		run_hi    = clip({2'b00, base} + {w_q, 1'b0}, cnt_q);
	end

	always_comb begin
		a_d   = a_q;
		b_d   = b_q;
		k_d   = k_q;
		mid_d = mid_q;
		hi_d  = hi_q;
		if (cmd.setup) begin
			a_d   = '0;
			k_d   = '0;
			b_d   = run_mid;
			mid_d = run_mid;
			hi_d  = run_hi;
		end else if (cmd.merge) begin
			k_d = k_inc;
			a_d = a_q + CW'(take_a);
			b_d = b_q + CW'(!take_a);
			if (run_done && !pass_done) begin
				a_d   = hi_q;
				k_d   = hi_q;
				b_d   = run_mid;
				mid_d = run_mid;
				hi_d  = run_hi;
			end
		end else if (emit_adv) begin
			a_d = a_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem0_q[cnt_q[AW-1:0]] <= in_value;
		end else if (cmd.merge && src_q) begin
			mem0_q[k_q[AW-1:0]] <= wdata;
		end
		if (cmd.merge && !src_q) begin
			mem1_q[k_q[AW-1:0]] <= wdata;
		end
		rd0a_q <= mem0_q[a_d[AW-1:0]];
		rd0b_q <= mem0_q[b_d[AW-1:0]];
		rd1a_q <= mem1_q[a_d[AW-1:0]];
		rd1b_q <= mem1_q[b_d[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			w_q         <= '0;
			src_q       <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			k_q         <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			a_q   <= a_d;
			b_q   <= b_d;
			k_q   <= k_d;
			mid_q <= mid_d;
			hi_q  <= hi_d;
			if (cmd.load) begin
				if (cnt_q < MaxCnt) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
				if (in_last) begin
					w_q   <= (CW+1)'(1);
					src_q <= 1'b0;
				end
			end
			if (pass_done) begin
				w_q   <= w_q << 1;
				src_q <= !src_q;
			end
			if (emit_adv && emit_last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
			if (emit_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_adv) begin
			out_value_q <= ra;
			out_last_q  <= emit_last;
			overflow_q  <= drop_q;
		end
	end

	assign sts.pass_done = pass_done;
	assign sts.sort_done = (w_q >= {1'b0, cnt_q});
	assign sts.emit_done = emit_adv && emit_last;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign overflow  = overflow_q;

endmodule
`default_nettype wire
